// ----- rtl/fisad_pkg.sv -----
`default_nettype none
package fisad_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    localparam logic [2:0] FM_NONE   = 3'd0;
    localparam logic [2:0] FM_CARRY0 = 3'd1;
    localparam logic [2:0] FM_CARRY1 = 3'd2;
    localparam logic [2:0] FM_BIT0   = 3'd3;
    localparam logic [2:0] FM_BIT1   = 3'd4;

    localparam logic [1:0] REG_FAULT_MODEL  = 2'd0;
    localparam logic [1:0] REG_TARGET_INDEX = 2'd1;
    localparam logic [1:0] REG_STUCK_POS    = 2'd2;

    localparam logic [2:0] RST_FAULT_MODEL  = FM_NONE;
    localparam logic [7:0] RST_TARGET_INDEX = 8'd17;
    localparam logic [3:0] RST_STUCK_POS    = 4'd7;

    typedef struct packed {
        logic [2:0] fault_model;
        logic [7:0] target_index;
        logic [3:0] stuck_pos;
    } fisad_cfg_t;

    typedef struct packed {
        logic [15:0] faulty;
        logic [15:0] clean;
        logic        inject;
        logic        last;
    } fisad_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOW,
        BK_HIGH
    } fisad_back_state_t;

endpackage
`default_nettype wire

// ----- rtl/fisad_front.sv -----
`default_nettype none
module fisad_front
    import fisad_pkg::*;
#(
    parameter int NUM_COEFFS = 256,
    parameter int WORD_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fisad_cfg_t  cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] share_a,
    input  wire logic [15:0] share_b,
    input  wire logic        q_full,
    output logic             push,
    output fisad_item_t      push_item
);

    localparam int PosBits = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
    localparam int AddBits = (WORD_BITS < 16) ? WORD_BITS : 16;
    localparam logic [15:0] WordMask = 16'((17'd1 << AddBits) - 17'd1);
    localparam logic [PosBits-1:0] LastPos = PosBits'(NUM_COEFFS - 1);

    logic [PosBits-1:0] pos_reg;
    logic [PosBits-1:0] pos_next;

    logic [15:0] a_m;
    logic [15:0] b_m;
    logic [15:0] clean;
    logic [3:0]  tb;
    logic [15:0] lo_mask;
    logic [15:0] hi_mask;
    logic [15:0] carry_bit;
    logic [15:0] bit_mask;
    logic [15:0] upper0;
    logic [15:0] upper1;
    logic [15:0] faulty_sel;
    logic        model_ok;
    logic        pos_match;
    logic        inject;
    logic        last;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign a_m   = share_a & WordMask;
    assign b_m   = share_b & WordMask;
    assign clean = (a_m + b_m) & WordMask;

    assign tb        = (32'(cfg.stuck_pos) >= 32'(WORD_BITS)) ? 4'd0 : cfg.stuck_pos;
    assign lo_mask   = 16'((17'd2 << tb) - 17'd1);
    assign hi_mask   = ~lo_mask & WordMask;
    assign carry_bit = 16'(17'd2 << tb);
    assign bit_mask  = 16'(17'd1 << tb);
    assign upper0    = ((a_m & hi_mask) + (b_m & hi_mask)) & hi_mask;
    assign upper1    = ((a_m & hi_mask) + (b_m & hi_mask) + carry_bit) & hi_mask;

    always_comb
    begin
        faulty_sel = clean;
        model_ok   = 1'b1;
        unique case (cfg.fault_model)
            FM_CARRY0: faulty_sel = (clean & lo_mask) | upper0;
            FM_CARRY1: faulty_sel = (clean & lo_mask) | upper1;
            FM_BIT0:   faulty_sel = clean & ~bit_mask;
            FM_BIT1:   faulty_sel = clean | bit_mask;
            default:   model_ok   = 1'b0;
        endcase
    end

    // out-of-range target falls back to position zero
    assign pos_match = (32'(cfg.target_index) < 32'(NUM_COEFFS))
                     ? (32'(pos_reg) == 32'(cfg.target_index))
                     : (pos_reg == '0);
    assign inject    = model_ok && pos_match;
    assign last      = (pos_reg == LastPos);

    assign push_item.faulty = inject ? faulty_sel : clean;
    assign push_item.clean  = clean;
    assign push_item.inject = inject;
    assign push_item.last   = last;

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = last ? '0 : pos_reg + PosBits'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/fisad_queue.sv -----
`default_nettype none
module fisad_queue
    import fisad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire fisad_item_t push_item,
    input  wire logic        pop,
    output logic             full,
    output logic             valid,
    output fisad_item_t      head
);

    fisad_item_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_pop;

    assign full   = (count_reg == 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/fisad_back.sv -----
`default_nettype none
module fisad_back
    import fisad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire fisad_item_t q_head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      result_word,
    output logic [15:0]      reference_word,
    output logic             fault_applied,
    output logic [31:0]      output_digest,
    output logic [31:0]      reference_digest,
    output logic             digests_match,
    output logic             block_last
);

    fisad_back_state_t state_reg;
    fisad_back_state_t state_next;
    fisad_item_t       item_reg;
    fisad_item_t       item_next;
    logic [31:0]       fh_reg;
    logic [31:0]       fh_next;
    logic [31:0]       ch_reg;
    logic [31:0]       ch_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              load_out;

    logic [15:0] res_word_reg;
    logic [15:0] ref_word_reg;
    logic        fault_reg;
    logic [31:0] out_dig_reg;
    logic [31:0] ref_dig_reg;
    logic        match_reg;
    logic        last_reg;

    logic [7:0]  f_byte;
    logic [7:0]  c_byte;
    logic [31:0] fh_mix;
    logic [31:0] ch_mix;
    logic        out_free;

    assign f_byte   = (state_reg == BK_HIGH) ? item_reg.faulty[15:8] : item_reg.faulty[7:0];
    assign c_byte   = (state_reg == BK_HIGH) ? item_reg.clean[15:8] : item_reg.clean[7:0];
    assign fh_mix   = (fh_reg ^ {24'd0, f_byte}) * FNV_PRIME;
    assign ch_mix   = (ch_reg ^ {24'd0, c_byte}) * FNV_PRIME;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        fh_next        = fh_reg;
        ch_next        = ch_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    item_next  = q_head;
                    state_next = BK_LOW;
                end
            end
            BK_LOW:
            begin
                fh_next    = fh_mix;
                ch_next    = ch_mix;
                state_next = BK_HIGH;
            end
            BK_HIGH:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    // digests restart after the last coefficient
                    fh_next        = item_reg.last ? FNV_BASIS : fh_mix;
                    ch_next        = item_reg.last ? FNV_BASIS : ch_mix;
                    if (q_valid)
                    begin
                        pop        = 1'b1;
                        item_next  = q_head;
                        state_next = BK_LOW;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fh_reg        <= FNV_BASIS;
            ch_reg        <= FNV_BASIS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fh_reg        <= fh_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (load_out)
        begin
            res_word_reg <= item_reg.faulty;
            ref_word_reg <= item_reg.clean;
            fault_reg    <= item_reg.inject;
            out_dig_reg  <= fh_mix;
            ref_dig_reg  <= ch_mix;
            match_reg    <= (fh_mix == ch_mix);
            last_reg     <= item_reg.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_word      = res_word_reg;
    assign reference_word   = ref_word_reg;
    assign fault_applied    = fault_reg;
    assign output_digest    = out_dig_reg;
    assign reference_digest = ref_dig_reg;
    assign digests_match    = match_reg;
    assign block_last       = last_reg;

endmodule
`default_nettype wire

// ----- rtl/fault_injected_share_adder_digest_top.sv -----
`default_nettype none
// channel   | dir | handshake                         | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready     | tdata: share_a, share_b
// m_axis    | out | m_axis_tvalid / m_axis_tready     | tdata: words and digests,
//           |     |                                   | tuser: flags, tlast: block_last
// apb       | in  | psel / penable / pwrite, pready=1 | fault_model, target_index, stuck_pos
//
// the back end hashes one byte of each word per cycle through its fnv multiply step, low
// byte then high byte, unless the high-byte step is held by the output register, and takes
// the next item in that step; items move queue, item register, output register
// reset clears control state, loads register defaults and the fnv offset basis
// input stays ready while the two-entry queue has room; the back end holds its
// high-byte step while the output register waits to be taken
module fault_injected_share_adder_digest_top
    import fisad_pkg::*;
#(
    parameter int NUM_COEFFS = 256,
    parameter int WORD_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // share_a, share_b

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // result_word, reference_word,
                                             // output_digest, reference_digest
    output logic [1:0]       m_axis_tuser,   // fault_applied, digests_match
    output logic             m_axis_tlast,   // block_last

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    fisad_cfg_t  cfg_reg;
    fisad_cfg_t  cfg_next;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    logic        q_full;
    logic        q_valid;
    logic        push;
    logic        pop;
    fisad_item_t push_item;
    fisad_item_t q_head;

    logic [15:0] result_word;
    logic [15:0] reference_word;
    logic        fault_applied;
    logic [31:0] output_digest;
    logic [31:0] reference_digest;
    logic        digests_match;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = 32'd0;
        unique case (cfg_idx)
            REG_FAULT_MODEL:
            begin
                prdata = {29'd0, cfg_reg.fault_model};
                if (cfg_wr)
                begin
                    cfg_next.fault_model = pwdata[2:0];
                end
            end
            REG_TARGET_INDEX:
            begin
                prdata = {24'd0, cfg_reg.target_index};
                if (cfg_wr)
                begin
                    cfg_next.target_index = pwdata[7:0];
                end
            end
            REG_STUCK_POS:
            begin
                prdata = {28'd0, cfg_reg.stuck_pos};
                if (cfg_wr)
                begin
                    cfg_next.stuck_pos = pwdata[3:0];
                end
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fault_model  <= RST_FAULT_MODEL;
            cfg_reg.target_index <= RST_TARGET_INDEX;
            cfg_reg.stuck_pos    <= RST_STUCK_POS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fisad_front #(
        .NUM_COEFFS (NUM_COEFFS),
        .WORD_BITS  (WORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .share_a   (s_axis_tdata[15:0]),
        .share_b   (s_axis_tdata[31:16]),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    fisad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    fisad_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_head           (q_head),
        .pop              (pop),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .result_word      (result_word),
        .reference_word   (reference_word),
        .fault_applied    (fault_applied),
        .output_digest    (output_digest),
        .reference_digest (reference_digest),
        .digests_match    (digests_match),
        .block_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {reference_digest, output_digest, reference_word, result_word};
    assign m_axis_tuser = {digests_match, fault_applied};

endmodule
`default_nettype wire

// ----- bench/tb_fault_injected_share_adder_digest_top.sv -----
module tb_fault_injected_share_adder_digest_top;
    import fisad_pkg::*;

    localparam int NUM_COEFFS  = 256;
    localparam int ITEM_TARGET = 450;
    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_CYCLES = 120;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] faulted_word;
        logic [15:0] clean_word;
        logic        inject;
        logic [31:0] faulted_digest;
        logic [31:0] clean_digest;
        logic        digest_eq;
        logic        block_end;
    } sum_record_t;

    class share_sum_tracker;
        logic [2:0]  model_reg;
        logic [7:0]  index_reg;
        logic [3:0]  bit_reg;
        int          position;
        logic [31:0] faulted_hash;
        logic [31:0] clean_hash;
        sum_record_t pending_sums[$];
        int          errors;

        function new();
            model_reg    = RST_FAULT_MODEL;
            index_reg    = RST_TARGET_INDEX;
            bit_reg      = RST_STUCK_POS;
            position     = 0;
            faulted_hash = FNV_BASIS;
            clean_hash   = FNV_BASIS;
            errors       = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FAULT_MODEL:  model_reg = value[2:0];
                REG_TARGET_INDEX: index_reg = value[7:0];
                REG_STUCK_POS:    bit_reg   = value[3:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] stuck_add(logic [15:0] a, logic [15:0] b, logic hit,
                                        logic [2:0] model, logic [3:0] bitpos);
            logic        carry;
            logic [15:0] sum;
            carry = 1'b0;
            sum   = '0;
            for (int i = 0; i < 16; i++) begin
                sum[i] = a[i] ^ b[i] ^ carry;
                carry  = (a[i] & b[i]) | (a[i] & carry) | (b[i] & carry);
                if (hit && i == int'(bitpos)) begin
                    case (model)
                        FM_CARRY0: carry  = 1'b0;
                        FM_CARRY1: carry  = 1'b1;
                        FM_BIT0:   sum[i] = 1'b0;
                        FM_BIT1:   sum[i] = 1'b1;
                        default: ;
                    endcase
                end
            end
            return sum;
        endfunction

        function logic [31:0] fnv_fold(logic [31:0] h, logic [15:0] w);
            logic [31:0] acc;
            acc = (h ^ {24'd0, w[7:0]}) * FNV_PRIME;
            acc = (acc ^ {24'd0, w[15:8]}) * FNV_PRIME;
            return acc;
        endfunction

        function void note_shares(logic [15:0] a, logic [15:0] b);
            sum_record_t rec;
            logic [2:0]  model;
            logic        hit;
            model = (model_reg >= FM_CARRY0 && model_reg <= FM_BIT1) ? model_reg : FM_NONE;
            hit   = (position == int'(index_reg)) && (model != FM_NONE);
            rec.faulted_word   = stuck_add(a, b, hit, model, bit_reg);
            rec.clean_word     = a + b;
            rec.inject         = hit;
            faulted_hash       = fnv_fold(faulted_hash, rec.faulted_word);
            clean_hash         = fnv_fold(clean_hash, rec.clean_word);
            rec.faulted_digest = faulted_hash;
            rec.clean_digest   = clean_hash;
            rec.digest_eq      = (faulted_hash == clean_hash);
            rec.block_end      = (position == NUM_COEFFS - 1);
            if (rec.block_end)
            begin
                position     = 0;
                faulted_hash = FNV_BASIS;
                clean_hash   = FNV_BASIS;
            end
            else
            begin
                position++;
            end
            pending_sums.push_back(rec);
        endfunction

        function int field_differs(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_sum(logic [95:0] data, logic [1:0] user, logic last);
            sum_record_t want;
            int          bad;
            if (pending_sums.size() == 0)
            begin
                $display("%0t unexpected result item: expected none actual %h %b %b",
                         $time, data, user, last);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            bad  = 0;
            bad += field_differs("result_word", 32'(want.faulted_word), 32'(data[15:0]));
            bad += field_differs("reference_word", 32'(want.clean_word), 32'(data[31:16]));
            bad += field_differs("output_digest", want.faulted_digest, data[63:32]);
            bad += field_differs("reference_digest", want.clean_digest, data[95:64]);
            bad += field_differs("fault_applied", 32'(want.inject), 32'(user[0]));
            bad += field_differs("digests_match", 32'(want.digest_eq), 32'(user[1]));
            bad += field_differs("block_last", 32'(want.block_end), 32'(last));
            if (bad != 0)
                errors++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // share_a, share_b
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;         // result_word, reference_word,
                                       // output_digest, reference_digest
    logic [1:0]  m_axis_tuser;         // fault_applied, digests_match
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    share_sum_tracker tracker = new();

    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    bit want_hold   = 1'b0;
    bit hold_done   = 1'b0;
    int stall_left  = 0;
    int sink_roll   = 0;
    int cycle_count = 0;
    int items_sent  = 0;

    fault_injected_share_adder_digest_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fault_injected_share_adder_digest_top test failed");
            $finish;
        end
    end

    // result side: random stalls plus one long hold
    always @(posedge clk)
    begin
        if (want_hold && !hold_done)
        begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (sink_steady)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 70)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left = (sink_roll < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_sum(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_steady || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_share();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_shares(logic [15:0] a, logic [15:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_shares(a, b);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_sums.size() != 0)
            @(posedge clk);
    endtask

    // junk above the field width is sometimes added; the block must drop it
    task automatic write_reg(logic [1:0] idx, logic [31:0] field, int width);
        logic [31:0] value;
        value = field;
        if ($urandom_range(0, 2) == 0)
            value = value | ($urandom << width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic set_fault(logic [2:0] model, logic [7:0] index, logic [3:0] bitpos);
        write_reg(REG_FAULT_MODEL, 32'(model), 3);
        write_reg(REG_TARGET_INDEX, 32'(index), 8);
        write_reg(REG_STUCK_POS, 32'(bitpos), 4);
    endtask

    task automatic run_fault_case(logic [2:0] model, logic [3:0] bitpos,
                                  logic [15:0] a, logic [15:0] b);
        set_fault(model, 8'(tracker.position), bitpos);
        push_shares(a, b);
        drain_results();
    endtask

    initial
    begin
        int          len;
        int          phase;
        logic [7:0]  index;
        logic [3:0]  bitpos;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        push_shares(16'h0000, 16'h0000);
        push_shares(16'hffff, 16'h0001);
        drain_results();

        run_fault_case(FM_CARRY0, 4'd7, 16'h00ff, 16'h0001);
        run_fault_case(FM_CARRY1, 4'd0, 16'h0000, 16'h0000);
        run_fault_case(FM_BIT0, 4'd15, 16'hffff, 16'h0000);
        run_fault_case(FM_BIT1, 4'd0, 16'h0000, 16'h0000);
        // forced carry out of the top bit leaves the word unchanged
        run_fault_case(FM_CARRY1, 4'd15, 16'hffff, 16'hffff);
        run_fault_case(FM_CARRY0, 4'd15, 16'h8000, 16'h8000);
        // undefined models behave as no fault
        run_fault_case(3'd5, 4'd3, 16'h1234, 16'h4321);
        run_fault_case(3'd6, 4'd9, 16'haaaa, 16'h5555);
        run_fault_case(3'd7, 4'd15, 16'h7fff, 16'h0001);
        run_fault_case(FM_BIT1, 4'd15, 16'h0000, 16'h0000);
        run_fault_case(FM_BIT0, 4'd0, 16'hffff, 16'hffff);

        // write to an address past the register list is ignored
        set_fault(FM_BIT1, 8'(tracker.position), 4'd4);
        write_reg(REG_SPARE, $urandom, 0);
        push_shares(16'h5555, 16'haaaa);
        push_shares(16'h0f0f, 16'hf0f0);
        drain_results();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            len = $urandom_range(8, 30);
            case ($urandom_range(0, 5))
                0: index = 8'd0;
                1: index = 8'd255;
                default: index = 8'((tracker.position + $urandom_range(0, len - 1)) % 256);
            endcase
            if (tracker.position >= NUM_COEFFS - 30)
            begin
                len   = NUM_COEFFS - tracker.position;
                index = 8'd255;
            end
            case ($urandom_range(0, 3))
                0: bitpos = 4'd0;
                1: bitpos = 4'd15;
                default: bitpos = 4'($urandom_range(0, 15));
            endcase
            set_fault(3'($urandom_range(0, 7)), index, bitpos);

            src_steady  = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            if (phase == 6)
            begin
                src_steady  = 1'b1;
                sink_steady = 1'b0;
                want_hold   = 1'b1;
            end
            repeat (len) push_shares(pick_share(), pick_share());
            drain_results();
            phase++;
        end

        sink_steady = 1'b1;
        drain_results();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_sums.size() == 0)
            $display("fault_injected_share_adder_digest_top test passed");
        else
            $display("fault_injected_share_adder_digest_top test failed");
        $finish;
    end

endmodule
